// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// cond in a cycle implies prop in the same cycle
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: check failed");
// cond in a cycle implies prop in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== hdl/bfsbi_pkg.sv =====
// Shared constants and control types of the blocking flow shop insertion block.
package bfsbi_pkg;

   localparam int OPCODE_W    = 2;
   localparam int POSITION_W  = 9;
   localparam int MACHINE_W   = 5;
   localparam int TIME_W      = 32;
   localparam int SUM_W       = 40;
   localparam int MCOUNT_W    = 6;
   localparam int SLEN_W      = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [OPCODE_W-1:0] OP_LOAD_TIME = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD_DEP  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COMPUTE   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MACHINE_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQUENCE_LENGTH = 2'd1;

   // tag that travels with each evaluation step down the datapath pipeline
   typedef struct packed {
      logic issue;     // a real (position, machine) step
      logic first;     // machine 0 of the position
      logic last;      // last machine in use
      logic pos_zero;  // insertion at the front
      logic flush;     // end-of-search marker, no step
   } tag_type;

   typedef struct packed {
      logic    load_time;
      logic    load_dep;
      logic    init;
      tag_type tag;
   } cmd_type;

endpackage

// ===== hdl/bfsbi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfsbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bfsbi_ctrl.sv =====
// Controller: configuration registers, position/machine sequencer and handshake.
module bfsbi_ctrl #(
   parameter int MAX_MACHINES = 32,
   parameter int MAX_JOBS = 256,
   localparam int MB = $clog2(MAX_MACHINES),
   localparam int PW = $clog2(MAX_JOBS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [bfsbi_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic                                  req_exclude_enable,
   input  logic [bfsbi_pkg::POSITION_W-1:0]      req_excluded_position,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bfsbi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bfsbi_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                  drain_done,
   output bfsbi_pkg::cmd_type                    cmd,
   output logic [PW-1:0]                         cmd_pos,
   output logic [MB-1:0]                         cmd_machine
);
   import bfsbi_pkg::*;

   localparam int CNT_W = $clog2(MAX_JOBS + 3);
   localparam int MCW   = $clog2(MAX_MACHINES + 1);
   localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [MB-1:0]           mach_ff, mach_in;
   logic                    excl_en_ff, excl_en_in;
   logic [POSITION_W-1:0]   excl_ff, excl_in;
   logic [MCOUNT_W-1:0]     mcount_ff;
   logic [SLEN_W-1:0]       slen_ff;

   logic                    accept;
   logic                    excl_zero;
   logic [CNT_W-1:0]        start_pos;
   logic [MCW-1:0]          m_eff;
   logic [MB-1:0]           last_machine;
   logic [CNT_W-1:0]        s_eff;
   logic [CNT_W-1:0]        pos_plus1;
   logic [CNT_W-1:0]        nxt_pos;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // clamp the registers into their legal ranges
   always_comb begin
      if (mcount_ff < MCOUNT_W'(2)) begin
         m_eff = MCW'(2);
      end else if (32'(mcount_ff) > 32'(MAX_MACHINES)) begin
         m_eff = MCW'(MAX_MACHINES);
      end else begin
         m_eff = MCW'(mcount_ff);
      end
      if (32'(slen_ff) > 32'(MAX_JOBS)) begin
         s_eff = CNT_W'(MAX_JOBS);
      end else begin
         s_eff = CNT_W'(slen_ff);
      end
   end

   assign last_machine = MB'(m_eff - MCW'(1));
   assign excl_zero    = req_exclude_enable && (req_excluded_position == '0);
   assign start_pos    = excl_zero ? CNT_W'(1) : '0;
   assign pos_plus1    = pos_ff + CNT_W'(1);
   // skip over the excluded position
   assign nxt_pos = (excl_en_ff && (CMP_W'(excl_ff) == CMP_W'(pos_plus1))) ?
                    pos_ff + CNT_W'(2) : pos_plus1;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      mach_in    = mach_ff;
      excl_en_in = excl_en_ff;
      excl_in    = excl_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_COMPUTE)) begin
               excl_en_in = req_exclude_enable;
               excl_in    = req_excluded_position;
               mach_in    = '0;
               pos_in     = start_pos;
               state_in   = (start_pos > s_eff) ? ST_FLUSH : ST_RUN;
            end
         end
         ST_RUN: begin
            if (mach_ff == last_machine) begin
               mach_in = '0;
               if (nxt_pos > s_eff) begin
                  state_in = ST_FLUSH;
               end else begin
                  pos_in = nxt_pos;
               end
            end else begin
               mach_in = mach_ff + MB'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         mach_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         mach_ff  <= mach_in;
      end
   end

   always_ff @(posedge clock) begin
      excl_en_ff <= excl_en_in;
      excl_ff    <= excl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcount_ff <= MCOUNT_W'(2);
         slen_ff   <= SLEN_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MACHINE_COUNT:   mcount_ff <= csr_data[MCOUNT_W-1:0];
            CSR_SEQUENCE_LENGTH: slen_ff   <= csr_data[SLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cmd.load_time    = accept && (req_opcode == OP_LOAD_TIME);
      cmd.load_dep     = accept && (req_opcode == OP_LOAD_DEP);
      cmd.init         = accept && (req_opcode == OP_COMPUTE);
      cmd.tag.issue    = (state_ff == ST_RUN);
      cmd.tag.first    = (mach_ff == '0);
      cmd.tag.last     = (mach_ff == last_machine);
      cmd.tag.pos_zero = (pos_ff == '0);
      cmd.tag.flush    = (state_ff == ST_FLUSH);
   end

   assign cmd_pos     = pos_ff[PW-1:0];
   assign cmd_machine = mach_ff;

endmodule

// ===== hdl/bfsbi_datapath.sv =====
// Datapath: stores, forward-row recurrence, makespan and best-position tracking.
module bfsbi_datapath #(
   parameter int MAX_MACHINES = 32,
   parameter int MAX_JOBS = 256,
   localparam int MB = $clog2(MAX_MACHINES),
   localparam int PW = $clog2(MAX_JOBS + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfsbi_pkg::cmd_type                   cmd,
   input  logic [PW-1:0]                        cmd_pos,
   input  logic [MB-1:0]                        cmd_machine,
   input  logic [bfsbi_pkg::POSITION_W-1:0]     req_position,
   input  logic [bfsbi_pkg::MACHINE_W-1:0]      req_machine,
   input  logic [bfsbi_pkg::TIME_W-1:0]         req_time_value,
   input  logic [bfsbi_pkg::TIME_W-1:0]         req_tail_value,
   input  logic                                 req_exclude_enable,
   input  logic [bfsbi_pkg::POSITION_W-1:0]     req_excluded_position,
   output logic                                 drain_done,
   output logic                                 rsp_valid,
   output logic [bfsbi_pkg::POSITION_W-1:0]     rsp_best_position,
   output logic [bfsbi_pkg::SUM_W-1:0]          rsp_best_makespan
);
   import bfsbi_pkg::*;

   localparam int DPW        = $clog2(MAX_JOBS);
   localparam int DEP_DEPTH  = MAX_JOBS << MB;
   localparam int TAIL_DEPTH = (MAX_JOBS + 1) << MB;
   localparam int DAW        = DPW + MB;
   localparam int TAW        = PW + MB;

   logic               m_ok;
   logic               p_we, dep_we, tail_we;
   logic [DAW-1:0]     dep_wr_addr, dep_blk_addr, dep_head_addr;
   logic [TAW-1:0]     tail_wr_addr, tail_rd_addr;
   logic [DPW-1:0]     pos_prev;
   logic [TIME_W-1:0]  p_rd, blk_rd, head_rd, tail_rd;

   tag_type            s2_ff, s3_ff, s4_ff;
   logic [PW-1:0]      s2_pos_ff, s3_pos_ff, s4_pos_ff;
   logic [SUM_W-1:0]   f_ff, f_in;
   logic [TIME_W-1:0]  q_ff;
   logic [SUM_W-1:0]   span_ff, span_in;
   logic [SUM_W-1:0]   best_val_ff;
   logic [PW-1:0]      best_idx_ff;
   logic               rsp_valid_ff;

   logic [SUM_W-1:0]   prev, step_sum, blk, total;
   logic               excl_zero, take;

   // load decode; out-of-range loads are dropped
   assign m_ok    = 32'(req_machine) < 32'(MAX_MACHINES);
   assign p_we    = cmd.load_time && m_ok;
   assign dep_we  = cmd.load_dep && m_ok && (32'(req_position) < 32'(MAX_JOBS));
   assign tail_we = cmd.load_dep && m_ok && (32'(req_position) <= 32'(MAX_JOBS));

   assign dep_wr_addr  = {DPW'(req_position), MB'(req_machine)};
   assign tail_wr_addr = {PW'(req_position), MB'(req_machine)};

   assign pos_prev      = DPW'(cmd_pos - PW'(1));
   assign dep_blk_addr  = {pos_prev, MB'(cmd_machine + MB'(1))};
   assign dep_head_addr = {pos_prev, {MB{1'b0}}};
   assign tail_rd_addr  = {cmd_pos, cmd_machine};

   bfsbi_ram #(.WIDTH(TIME_W), .DEPTH(MAX_MACHINES)) u_p_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (MB'(req_machine)),
      .wr_data (req_time_value),
      .rd_addr (cmd_machine),
      .rd_data (p_rd)
   );

   // two copies of the departure store: blocking term and machine-0 head
   bfsbi_ram #(.WIDTH(TIME_W), .DEPTH(DEP_DEPTH)) u_dep_blk_ram (
      .clock   (clock),
      .wr_en   (dep_we),
      .wr_addr (dep_wr_addr),
      .wr_data (req_time_value),
      .rd_addr (dep_blk_addr),
      .rd_data (blk_rd)
   );

   bfsbi_ram #(.WIDTH(TIME_W), .DEPTH(DEP_DEPTH)) u_dep_head_ram (
      .clock   (clock),
      .wr_en   (dep_we),
      .wr_addr (dep_wr_addr),
      .wr_data (req_time_value),
      .rd_addr (dep_head_addr),
      .rd_data (head_rd)
   );

   bfsbi_ram #(.WIDTH(TIME_W), .DEPTH(TAIL_DEPTH)) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_we),
      .wr_addr (tail_wr_addr),
      .wr_data (req_tail_value),
      .rd_addr (tail_rd_addr),
      .rd_data (tail_rd)
   );

   // stage 2: forward row, one machine per cycle
   always_comb begin
      if (s2_ff.first) begin
         prev = s2_ff.pos_zero ? '0 : SUM_W'(head_rd);
      end else begin
         prev = f_ff;
      end
      step_sum = prev + SUM_W'(p_rd);
      blk      = SUM_W'(blk_rd);
      f_in     = (!s2_ff.pos_zero && !s2_ff.last && (blk > step_sum)) ? blk : step_sum;
   end

   // stage 3: running makespan of the position
   assign total   = f_ff + SUM_W'(q_ff);
   assign span_in = (s3_ff.first || (total > span_ff)) ? total : span_ff;

   // stage 4: strict compare keeps the earliest position on ties
   assign take      = s4_ff.issue && s4_ff.last && (span_ff < best_val_ff);
   assign excl_zero = req_exclude_enable && (req_excluded_position == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff        <= '0;
         s3_ff        <= '0;
         s4_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_ff        <= cmd.tag;
         s3_ff        <= s2_ff;
         s4_ff        <= s3_ff;
         rsp_valid_ff <= s4_ff.flush;
      end
   end

   always_ff @(posedge clock) begin
      s2_pos_ff <= cmd_pos;
      s3_pos_ff <= s2_pos_ff;
      s4_pos_ff <= s3_pos_ff;
      q_ff      <= tail_rd;
      if (s2_ff.issue) begin
         f_ff <= f_in;
      end
      if (s3_ff.issue) begin
         span_ff <= span_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_val_ff <= '1;
         best_idx_ff <= '0;
      end else if (cmd.init) begin
         best_val_ff <= '1;
         best_idx_ff <= excl_zero ? PW'(1) : '0;
      end else if (take) begin
         best_val_ff <= span_ff;
         best_idx_ff <= s4_pos_ff;
      end
   end

   assign drain_done        = s4_ff.flush;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_position = POSITION_W'(best_idx_ff);
   assign rsp_best_makespan = best_val_ff;

endmodule

// ===== hdl/blocking_flowshop_best_insertion_top.sv =====
// Top level of the blocking flow shop best-insertion block.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+--------------------------------------
//  request  | start, busy, req_*            | word taken when start && !busy
//  response | rsp_valid, rsp_*              | one-cycle strobe, cannot be held off
//  config   | csr_valid, csr_ready, csr_*   | word written when csr_valid && csr_ready
//
// Load words leave busy low, so loads stream back to back. A compute word keeps
// busy high while the sequencer steps through the N insertion positions evaluated,
// each over the m machines in use, and while the end-of-search marker drains; the
// result strobe comes in the cycle busy falls. The forward-row recurrence advances
// one machine per cycle through a single add/max unit fed by registered memory
// reads. Reset is synchronous; the stores are not cleared. The response side has no
// stall: rsp_valid pulses once per compute word.
`include "assert_macros.svh"

module blocking_flowshop_best_insertion_top #(
   parameter int MAX_MACHINES = 32,
   parameter int MAX_JOBS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [bfsbi_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [bfsbi_pkg::POSITION_W-1:0]     req_position,
   input  logic [bfsbi_pkg::MACHINE_W-1:0]      req_machine,
   input  logic [bfsbi_pkg::TIME_W-1:0]         req_time_value,
   input  logic [bfsbi_pkg::TIME_W-1:0]         req_tail_value,
   input  logic                                 req_exclude_enable,
   input  logic [bfsbi_pkg::POSITION_W-1:0]     req_excluded_position,
   output logic                                 rsp_valid,
   output logic [bfsbi_pkg::POSITION_W-1:0]     rsp_best_position,
   output logic [bfsbi_pkg::SUM_W-1:0]          rsp_best_makespan,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bfsbi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfsbi_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bfsbi_pkg::*;

   localparam int MB = $clog2(MAX_MACHINES);
   localparam int PW = $clog2(MAX_JOBS + 1);

   // command from the sequencer: load strobes, search init and the step tag
   cmd_type         cmd;
   logic [PW-1:0]   cmd_pos;
   logic [MB-1:0]   cmd_machine;
   // end-of-search marker has left the pipeline
   logic            drain_done;

   bfsbi_ctrl #(
      .MAX_MACHINES (MAX_MACHINES),
      .MAX_JOBS     (MAX_JOBS)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_exclude_enable    (req_exclude_enable),
      .req_excluded_position (req_excluded_position),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .drain_done            (drain_done),
      .cmd                   (cmd),
      .cmd_pos               (cmd_pos),
      .cmd_machine           (cmd_machine)
   );

   // stores, the four-stage step pipeline and the best-position register
   bfsbi_datapath #(
      .MAX_MACHINES (MAX_MACHINES),
      .MAX_JOBS     (MAX_JOBS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .cmd_pos               (cmd_pos),
      .cmd_machine           (cmd_machine),
      .req_position          (req_position),
      .req_machine           (req_machine),
      .req_time_value        (req_time_value),
      .req_tail_value        (req_tail_value),
      .req_exclude_enable    (req_exclude_enable),
      .req_excluded_position (req_excluded_position),
      .drain_done            (drain_done),
      .rsp_valid             (rsp_valid),
      .rsp_best_position     (rsp_best_position),
      .rsp_best_makespan     (rsp_best_makespan)
   );

   // a result is only shown once the sequencer is back to idle
   `ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   // a compute word always starts a search
   `ASSERT_NEXT(a_compute_goes_busy, clock, reset, start && !busy && req_opcode == OP_COMPUTE, busy)
   // one strobe per search, never two in a row
   `ASSERT_NEXT(a_rsp_single_pulse, clock, reset, rsp_valid, !rsp_valid)
   // the sequencer never issues steps while idle
   `ASSERT_IMPLY(a_issue_while_busy, clock, reset, cmd.tag.issue || cmd.tag.flush, busy)

endmodule
